/* rtl/wsf_pkg.sv */
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types, register indexes, opcodes and constants for the wheel speed
// filter and odometry block.
// ----------------------------------------------------------------------------
package wsf_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 8'd3;

  localparam logic [23:0] COUNT_SCALE_RST = 24'd0;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd131072;
  localparam logic [23:0] TURN_GAIN_RST   = 24'd65536;
  localparam logic [3:0]  INVERT_MASK_RST = 4'd9;

  // filter coefficient, 0.2 in Q0.16
  localparam logic signed [24:0] ALPHA_Q16 = 25'sd13107;

  // datapath opcodes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_RAW    = 3'd1;
  localparam logic [2:0] OP_ALPHA  = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_YAW    = 3'd4;
  localparam logic [2:0] OP_RESULT = 3'd5;

  typedef struct packed {
    logic signed [15:0] count_0;
    logic signed [15:0] count_1;
    logic signed [15:0] count_2;
    logic signed [15:0] count_3;
  } wsf_in_t;

  typedef struct packed {
    logic signed [31:0] speed_0;
    logic signed [31:0] speed_1;
    logic signed [31:0] speed_2;
    logic signed [31:0] speed_3;
    logic signed [31:0] forward_velocity;
    logic signed [31:0] yaw_rate;
  } wsf_out_t;

  typedef struct packed {
    logic [23:0] count_scale;
    logic [30:0] speed_limit;
    logic [23:0] turn_gain;
    logic [3:0]  invert_mask;
  } wsf_cfg_t;

  typedef struct packed {
    logic       load_in;
    logic [2:0] op;
    logic [1:0] wheel;
  } wsf_cmd_t;

endpackage

/* rtl/wsf_ctrl.sv */
// ----------------------------------------------------------------------------
// wsf_ctrl
// Sequencer: walks the four wheels through scale, filter and update steps,
// then the odometry step, and owns the result valid flag.
// ----------------------------------------------------------------------------
module wsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wsf_pkg::wsf_cmd_t cmd
);
  import wsf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RAW   = 3'd1;
  localparam logic [2:0] S_ALPHA = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_YAW   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] wheel_r, wheel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       res_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    wheel_nxt   = wheel_r;
    res_fire    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.op      = OP_NONE;
    cmd.wheel   = wheel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          wheel_nxt   = 2'd0;
          state_nxt   = S_RAW;
        end
      end
      S_RAW: begin
        cmd.op    = OP_RAW;
        state_nxt = S_ALPHA;
      end
      S_ALPHA: begin
        cmd.op    = OP_ALPHA;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        if (wheel_r == 2'd3) begin
          state_nxt = S_YAW;
        end else begin
          wheel_nxt = wheel_r + 2'd1;
          state_nxt = S_RAW;
        end
      end
      S_YAW: begin
        cmd.op    = OP_YAW;
        state_nxt = S_RES;
      end
      S_RES: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_RESULT;
          res_fire  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || res_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/wsf_datapath.sv */
// ----------------------------------------------------------------------------
// wsf_datapath
// Shared multiplier, per-wheel filter state, odometry sums and the result
// register, driven step by step by the sequencer.
// ----------------------------------------------------------------------------
module wsf_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  wsf_pkg::wsf_cmd_t cmd,
  input  wsf_pkg::wsf_cfg_t cfg,
  input  wsf_pkg::wsf_in_t  in_data,
  output wsf_pkg::wsf_out_t out_data
);
  import wsf_pkg::*;

  wsf_in_t            in_r;
  wsf_out_t           out_r;
  logic signed [31:0] filt_r [4];
  logic signed [58:0] prod_r, prod_nxt;
  logic signed [31:0] fwd_r;

  logic signed [15:0] cnt_sel;
  logic signed [16:0] cnt_ext;
  logic signed [31:0] f_sel;
  logic signed [58:0] lim_pos, lim_neg, raw_full;
  logic signed [31:0] raw;
  logic signed [32:0] diff_f;
  logic signed [32:0] step;
  logic signed [32:0] f_new;
  logic signed [33:0] sum4, diff4;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] yaw_full;
  logic signed [31:0] yaw_sat;

  always_comb begin
    unique case (cmd.wheel)
      2'd0: cnt_sel = in_r.count_0;
      2'd1: cnt_sel = in_r.count_1;
      2'd2: cnt_sel = in_r.count_2;
      2'd3: cnt_sel = in_r.count_3;
      default: cnt_sel = in_r.count_0;
    endcase
  end

  // widen before negating so the most negative count flips exactly
  assign cnt_ext = cfg.invert_mask[cmd.wheel] ? -{cnt_sel[15], cnt_sel}
                                              : {cnt_sel[15], cnt_sel};
  assign f_sel   = filt_r[cmd.wheel];

  // clamp the scaled count to the speed limit
  assign lim_pos = $signed({28'd0, cfg.speed_limit});
  assign lim_neg = -lim_pos;
  always_comb begin
    priority if (prod_r > lim_pos) begin
      raw_full = lim_pos;
    end else if (prod_r < lim_neg) begin
      raw_full = lim_neg;
    end else begin
      raw_full = prod_r;
    end
  end
  assign raw    = raw_full[31:0];
  assign diff_f = {raw[31], raw} - {f_sel[31], f_sel};

  // alpha * (raw - f) >>> 16 lies between zero and raw - f
  assign step  = prod_r[48:16];
  assign f_new = {f_sel[31], f_sel} + step;

  assign sum4  = 34'(filt_r[0]) + 34'(filt_r[1]) + 34'(filt_r[2]) + 34'(filt_r[3]);
  assign diff4 = 34'(filt_r[1]) + 34'(filt_r[2]) - 34'(filt_r[0]) - 34'(filt_r[3]);

  always_comb begin
    unique case (cmd.op)
      OP_RAW: begin
        mul_a = 34'(cnt_ext);
        mul_b = $signed({1'b0, cfg.count_scale});
      end
      OP_ALPHA: begin
        mul_a = 34'(diff_f);
        mul_b = ALPHA_Q16;
      end
      OP_YAW: begin
        mul_a = diff4;
        mul_b = $signed({1'b0, cfg.turn_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = 59'(mul_a) * 59'(mul_b);

  assign yaw_full = prod_r[58:17];
  always_comb begin
    if (yaw_full[41:31] != {11{yaw_full[31]}}) begin
      yaw_sat = yaw_full[41] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      yaw_sat = yaw_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.op == OP_RAW || cmd.op == OP_ALPHA || cmd.op == OP_YAW) begin
      prod_r <= prod_nxt;
    end
    if (cmd.op == OP_YAW) begin
      fwd_r <= sum4[33:2];
    end
    if (cmd.op == OP_RESULT) begin
      out_r.speed_0          <= filt_r[0];
      out_r.speed_1          <= filt_r[1];
      out_r.speed_2          <= filt_r[2];
      out_r.speed_3          <= filt_r[3];
      out_r.forward_velocity <= fwd_r;
      out_r.yaw_rate         <= yaw_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        filt_r[i] <= '0;
      end
    end else if (cmd.op == OP_UPDATE) begin
      filt_r[cmd.wheel] <= f_new[31:0];
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/wheel_speed_filter_odometry.sv */
// ----------------------------------------------------------------------------
// wheel_speed_filter_odometry
// Per-wheel encoder speed scaling, clamping and exponential smoothing, with
// forward velocity and yaw rate for a four-wheel differential chassis.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    in_data   (four count deltas)
//  out      out_valid / out_ready  out_data  (four speeds, forward, yaw)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A tick runs three steps per wheel (scale and filter on the single shared
//  multiplier, then update), then the yaw product and result load. A new tick
//  is taken only once the previous one is through and the sequencer is idle.
//  A finished result sits in the output register; the next tick is taken while
//  it waits, and the result load holds until that register is free.
//  Reset (synchronous) clears the filter state and restores register defaults.
// ----------------------------------------------------------------------------
module wheel_speed_filter_odometry (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wsf_pkg::wsf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wsf_pkg::wsf_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wsf_pkg::*;

  wsf_cfg_t cfg_r;
  wsf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // out-of-range indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_scale <= COUNT_SCALE_RST;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
      cfg_r.turn_gain   <= TURN_GAIN_RST;
      cfg_r.invert_mask <= INVERT_MASK_RST;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        REG_COUNT_SCALE: cfg_r.count_scale <= cfg_data[23:0];
        REG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_data[30:0];
        REG_TURN_GAIN:   cfg_r.turn_gain   <= cfg_data[23:0];
        REG_INVERT_MASK: cfg_r.invert_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  wsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  wsf_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
